[rtl/qrs_pkg.sv]
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int TOL_BITS  = 16;

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int RAD_BITS  = 2 * WORD_BITS + 2;
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 2;
  localparam int DEN_BITS  = WORD_BITS + 1;
  localparam int SUM_BITS  = WORD_BITS + 3;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS + 4;
  localparam int DVS_BITS  = DEN_BITS + 1;
  localparam int QUO_BITS  = WORD_BITS;
  localparam int HEAD_BITS = NUM_BITS - QUO_BITS;
  localparam int CMP_BITS  = (HEAD_BITS > DVS_BITS) ? HEAD_BITS : DVS_BITS;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INF,
    KIND_LINEAR,
    KIND_QUAD
  } qrs_kind_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] coef_quadratic;
    logic signed [WORD_BITS-1:0] coef_linear;
    logic signed [WORD_BITS-1:0] coef_constant;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]                  root_count;
    logic signed [WORD_BITS-1:0] first_root;
    logic signed [WORD_BITS-1:0] second_root;
    logic                        range_overflow;
  } qrs_out_t;

  typedef struct packed {
    qrs_kind_t           kind;
    logic [DEN_BITS-1:0] pnum;
    logic [DEN_BITS-1:0] den;
  } qrs_side_t;

  typedef struct packed {
    logic [1:0] count;
    logic       use_lo;
    logic       use_hi;
  } qrs_tag_t;

endpackage

[rtl/quadratic_root_solver_core.sv]
// quadratic root solver, one equation a*x^2 + b*x + c = 0 per transfer
// input channel: in_valid / in_stall / in_data carry the three signed
//   Q16.16 coefficients; a transfer takes place when in_valid is high
//   and in_stall is low
// result channel: out_valid / out_stall / out_data carry root count,
//   both roots and the saturation flag, one result per input transfer
// configuration: cfg_wr_en / cfg_wr_data write the zero tolerance;
//   write it only while no equation is in flight
// latency: 3 + (WORD_BITS + 1) + 2 + WORD_BITS + 1 cycles, 71 at 32 bits,
//   set by the bit-per-stage square root and the bit-per-stage divider
// throughput: one equation per cycle, all stages advance together
// stall: while a result waits with out_stall high the whole pipeline
//   holds and in_stall is raised; nothing is lost or repeated
// reset: rst_n low clears every valid bit and the tolerance to zero
module quadratic_root_solver_core import qrs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qrs_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qrs_out_t            out_data,
  input  logic                cfg_wr_en,
  input  logic [TOL_BITS-1:0] cfg_wr_data
);

  logic [TOL_BITS-1:0]  tol_r;
  logic                 adv;
  logic                 fr_valid;
  logic [RAD_BITS-1:0]  fr_rad;
  qrs_side_t            fr_side;
  logic                 sq_valid;
  logic [ROOT_BITS-1:0] sq_root;
  qrs_side_t            sq_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  qrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .tol       (tol_r),
    .out_valid (fr_valid),
    .out_rad   (fr_rad),
    .out_side  (fr_side)
  );

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fr_valid),
    .in_rad    (fr_rad),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  qrs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_empty_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.root_count == CNT_NONE || out_data.root_count == CNT_INF)
    |-> out_data.first_root == '0 && out_data.second_root == '0
        && !out_data.range_overflow)
    else $error("roots or flag set without a root");

  a_single_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.root_count == CNT_ONE
    |-> out_data.second_root == '0 || out_data.second_root == out_data.first_root)
    else $error("single root with a different second root");

  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_overflow
    |-> out_data.first_root == {1'b0, {(WORD_BITS-1){1'b1}}}
        || out_data.first_root == {1'b1, {(WORD_BITS-1){1'b0}}}
        || out_data.second_root == {1'b0, {(WORD_BITS-1){1'b1}}}
        || out_data.second_root == {1'b1, {(WORD_BITS-1){1'b0}}})
    else $error("overflow flag without a saturated root");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(fr_valid) && $stable(sq_valid) && $stable(out_valid))
    else $error("pipeline moved during a stall");

endmodule

[rtl/qrs_front.sv]
module qrs_front import qrs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  qrs_in_t             in_data,
  input  logic [TOL_BITS-1:0] tol,
  output logic                out_valid,
  output logic [RAD_BITS-1:0] out_rad,
  output qrs_side_t           out_side
);

  function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] v);
    mag_of = v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // stage 1: magnitudes and zero tests
  logic                 v1_r;
  logic [WORD_BITS-1:0] a1_r, b1_r, c1_r;
  logic [WORD_BITS-1:0] ma1_r, mb1_r, mc1_r;
  logic                 za1_r, zb1_r, zc1_r;
  logic [WORD_BITS-1:0] ma_nxt, mb_nxt, mc_nxt;
  logic                 za_nxt, zb_nxt, zc_nxt;

  // stage 2: products
  logic                 v2_r;
  logic [PROD_BITS-1:0] bb2_r, ac2_r;
  logic [WORD_BITS-1:0] a2_r, b2_r, c2_r;
  logic                 za2_r, zb2_r, zc2_r, acn2_r;
  logic                 acn_nxt;

  // stage 3: discriminant and case
  logic                 v3_r;
  logic [RAD_BITS-1:0]  rad3_r, rad_nxt;
  qrs_side_t            side3_r, side_nxt;
  logic [RAD_BITS-1:0]  bbx, acx;
  logic                 d_neg;
  logic [DEN_BITS-1:0]  bx, cx;

  always_comb begin
    ma_nxt = mag_of(in_data.coef_quadratic);
    mb_nxt = mag_of(in_data.coef_linear);
    mc_nxt = mag_of(in_data.coef_constant);
    za_nxt = (in_data.coef_quadratic == '0) || (ma_nxt < WORD_BITS'(tol));
    zb_nxt = (in_data.coef_linear == '0) || (mb_nxt < WORD_BITS'(tol));
    zc_nxt = (in_data.coef_constant == '0) || (mc_nxt < WORD_BITS'(tol));
  end

  assign acn_nxt = (a1_r[WORD_BITS-1] != c1_r[WORD_BITS-1]) && (c1_r != '0);

  always_comb begin
    bbx   = RAD_BITS'(bb2_r);
    acx   = RAD_BITS'(ac2_r) << 2;
    d_neg = !acn2_r && (bbx < acx);
    rad_nxt = acn2_r ? (bbx + acx) : (bbx - acx);
    bx = {b2_r[WORD_BITS-1], b2_r};
    cx = {c2_r[WORD_BITS-1], c2_r};
    if (za2_r) begin
      side_nxt.pnum = ~cx + 1'b1;
      side_nxt.den  = bx;
      if (zb2_r) begin
        side_nxt.kind = zc2_r ? KIND_INF : KIND_NONE;
      end else begin
        side_nxt.kind = KIND_LINEAR;
      end
    end else begin
      side_nxt.pnum = ~bx + 1'b1;
      side_nxt.den  = {a2_r, 1'b0};
      side_nxt.kind = d_neg ? KIND_NONE : KIND_QUAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r    <= in_data.coef_quadratic;
      b1_r    <= in_data.coef_linear;
      c1_r    <= in_data.coef_constant;
      ma1_r   <= ma_nxt;
      mb1_r   <= mb_nxt;
      mc1_r   <= mc_nxt;
      za1_r   <= za_nxt;
      zb1_r   <= zb_nxt;
      zc1_r   <= zc_nxt;
      bb2_r   <= mb1_r * mb1_r;
      ac2_r   <= ma1_r * mc1_r;
      a2_r    <= a1_r;
      b2_r    <= b1_r;
      c2_r    <= c1_r;
      za2_r   <= za1_r;
      zb2_r   <= zb1_r;
      zc2_r   <= zc1_r;
      acn2_r  <= acn_nxt;
      rad3_r  <= rad_nxt;
      side3_r <= side_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_rad   = rad3_r;
  assign out_side  = side3_r;

endmodule

[rtl/qrs_sqrt.sv]
module qrs_sqrt import qrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [RAD_BITS-1:0]  in_rad,
  input  qrs_side_t            in_side,
  output logic                 out_valid,
  output logic [ROOT_BITS-1:0] out_root,
  output qrs_side_t            out_side
);

  logic [ROOT_BITS-1:0] v_r, v_nxt;
  logic [REM_BITS-1:0]  rem_r  [ROOT_BITS];
  logic [REM_BITS-1:0]  rem_nxt[ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_nxt[ROOT_BITS];
  logic [RAD_BITS-1:0]  rad_r  [ROOT_BITS];
  logic [RAD_BITS-1:0]  rad_nxt[ROOT_BITS];
  qrs_side_t            side_r  [ROOT_BITS];
  qrs_side_t            side_nxt[ROOT_BITS];

  // one result bit per stage, two radicand bits shifted in
  always_comb begin
    logic [REM_BITS-1:0]  rem_p;
    logic [ROOT_BITS-1:0] root_p;
    logic [RAD_BITS-1:0]  rad_p;
    logic [REM_BITS+1:0]  sh;
    logic [REM_BITS+1:0]  trial;
    for (int k = 0; k < ROOT_BITS; k++) begin
      if (k == 0) begin
        rem_p       = '0;
        root_p      = '0;
        rad_p       = in_rad;
        v_nxt[k]    = in_valid;
        side_nxt[k] = in_side;
      end else begin
        rem_p       = rem_r[k-1];
        root_p      = root_r[k-1];
        rad_p       = rad_r[k-1];
        v_nxt[k]    = v_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      sh    = {rem_p, rad_p[RAD_BITS-1 -: 2]};
      trial = (REM_BITS+2)'({root_p, 2'b01});
      if (sh >= trial) begin
        rem_nxt[k]  = REM_BITS'(sh - trial);
        root_nxt[k] = {root_p[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = REM_BITS'(sh);
        root_nxt[k] = {root_p[ROOT_BITS-2:0], 1'b0};
      end
      rad_nxt[k] = {rad_p[RAD_BITS-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < ROOT_BITS; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = v_r[ROOT_BITS-1];
  assign out_root  = root_r[ROOT_BITS-1];
  assign out_side  = side_r[ROOT_BITS-1];

endmodule

[rtl/qrs_div.sv]
module qrs_div import qrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [ROOT_BITS-1:0] in_root,
  input  qrs_side_t            in_side,
  output logic                 out_valid,
  output qrs_out_t             out_data
);

  // stage a: numerators and root count
  logic                va_r;
  logic [SUM_BITS-1:0] num_a_r[2];
  logic [SUM_BITS-1:0] num_a_nxt[2];
  logic [DEN_BITS-1:0] den_a_r;
  qrs_tag_t            tag_a_r, tag_a_nxt;
  logic [SUM_BITS-1:0] sx, px;

  // stage b (index 0) and quotient steps (1 .. QUO_BITS)
  logic [QUO_BITS:0]   v_r, v_nxt;
  logic [DVS_BITS-1:0] rem_r  [QUO_BITS+1][2];
  logic [DVS_BITS-1:0] rem_nxt[QUO_BITS+1][2];
  logic [QUO_BITS-1:0] low_r  [QUO_BITS+1][2];
  logic [QUO_BITS-1:0] low_nxt[QUO_BITS+1][2];
  logic [DVS_BITS-1:0] dvs_r  [QUO_BITS+1][2];
  logic [DVS_BITS-1:0] dvs_nxt[QUO_BITS+1][2];
  logic                neg_r  [QUO_BITS+1][2];
  logic                neg_nxt[QUO_BITS+1][2];
  logic                pov_r  [QUO_BITS+1][2];
  logic                pov_nxt[QUO_BITS+1][2];
  qrs_tag_t            tag_r  [QUO_BITS+1];
  qrs_tag_t            tag_nxt[QUO_BITS+1];

  // final saturation, sign and root selection
  logic                vo_r;
  qrs_out_t            out_r, out_nxt;

  always_comb begin
    sx = (in_side.kind == KIND_QUAD) ? SUM_BITS'(in_root) : '0;
    px = {{(SUM_BITS-DEN_BITS){in_side.pnum[DEN_BITS-1]}}, in_side.pnum};
    num_a_nxt[0] = px - sx;
    num_a_nxt[1] = px + sx;
    unique case (in_side.kind)
      KIND_NONE: begin
        tag_a_nxt = '{count: CNT_NONE, use_lo: 1'b0, use_hi: 1'b0};
      end
      KIND_INF: begin
        tag_a_nxt = '{count: CNT_INF, use_lo: 1'b0, use_hi: 1'b0};
      end
      KIND_LINEAR: begin
        tag_a_nxt = '{count: CNT_ONE, use_lo: 1'b1, use_hi: 1'b0};
      end
      KIND_QUAD: begin
        // a zero root of the discriminant means a double root
        tag_a_nxt = '{count: (in_root == '0) ? CNT_ONE : CNT_TWO,
                      use_lo: 1'b1, use_hi: 1'b1};
      end
    endcase
  end

  always_comb begin
    logic [SUM_BITS-1:0]  mn;
    logic [DEN_BITS-1:0]  md;
    logic [NUM_BITS-1:0]  nn;
    logic [HEAD_BITS-1:0] head;
    logic [DVS_BITS-1:0]  dvs;
    logic [DVS_BITS:0]    sh;
    for (int l = 0; l < 2; l++) begin
      mn   = num_a_r[l][SUM_BITS-1] ? (~num_a_r[l] + 1'b1) : num_a_r[l];
      md   = den_a_r[DEN_BITS-1] ? (~den_a_r + 1'b1) : den_a_r;
      // rounding to nearest: (2n + d) / 2d
      nn   = (NUM_BITS'(mn) << (FRAC_BITS + 1)) + NUM_BITS'(md);
      head = nn[NUM_BITS-1 -: HEAD_BITS];
      dvs  = {md, 1'b0};
      rem_nxt[0][l] = DVS_BITS'(head);
      low_nxt[0][l] = nn[QUO_BITS-1:0];
      dvs_nxt[0][l] = dvs;
      neg_nxt[0][l] = num_a_r[l][SUM_BITS-1] != den_a_r[DEN_BITS-1];
      pov_nxt[0][l] = CMP_BITS'(head) >= CMP_BITS'(dvs);
      for (int k = 1; k <= QUO_BITS; k++) begin
        sh = {rem_r[k-1][l], low_r[k-1][l][QUO_BITS-1]};
        if (sh >= {1'b0, dvs_r[k-1][l]}) begin
          rem_nxt[k][l] = DVS_BITS'(sh - {1'b0, dvs_r[k-1][l]});
          low_nxt[k][l] = {low_r[k-1][l][QUO_BITS-2:0], 1'b1};
        end else begin
          rem_nxt[k][l] = DVS_BITS'(sh);
          low_nxt[k][l] = {low_r[k-1][l][QUO_BITS-2:0], 1'b0};
        end
        dvs_nxt[k][l] = dvs_r[k-1][l];
        neg_nxt[k][l] = neg_r[k-1][l];
        pov_nxt[k][l] = pov_r[k-1][l];
      end
    end
    v_nxt[0]   = va_r;
    tag_nxt[0] = tag_a_r;
    for (int k = 1; k <= QUO_BITS; k++) begin
      v_nxt[k]   = v_r[k-1];
      tag_nxt[k] = tag_r[k-1];
    end
  end

  always_comb begin
    logic [QUO_BITS-1:0] q;
    logic [QUO_BITS-1:0] lim;
    logic [QUO_BITS-1:0] m;
    logic                ovf[2];
    logic [QUO_BITS-1:0] res[2];
    for (int l = 0; l < 2; l++) begin
      q      = low_r[QUO_BITS][l];
      lim    = {1'b1, {(QUO_BITS-1){1'b0}}} - QUO_BITS'(!neg_r[QUO_BITS][l]);
      ovf[l] = pov_r[QUO_BITS][l] || (q > lim);
      m      = ovf[l] ? lim : q;
      res[l] = neg_r[QUO_BITS][l] ? (~m + 1'b1) : m;
    end
    out_nxt.root_count     = tag_r[QUO_BITS].count;
    out_nxt.first_root     = tag_r[QUO_BITS].use_lo ? res[0] : '0;
    out_nxt.second_root    = tag_r[QUO_BITS].use_hi ? res[1] : '0;
    out_nxt.range_overflow = (tag_r[QUO_BITS].use_lo && ovf[0]) ||
                             (tag_r[QUO_BITS].use_hi && ovf[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      v_r  <= '0;
      vo_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      v_r  <= v_nxt;
      vo_r <= v_r[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_a_r[0] <= num_a_nxt[0];
      num_a_r[1] <= num_a_nxt[1];
      den_a_r    <= in_side.den;
      tag_a_r    <= tag_a_nxt;
      for (int k = 0; k <= QUO_BITS; k++) begin
        tag_r[k] <= tag_nxt[k];
        for (int l = 0; l < 2; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          low_r[k][l] <= low_nxt[k][l];
          dvs_r[k][l] <= dvs_nxt[k][l];
          neg_r[k][l] <= neg_nxt[k][l];
          pov_r[k][l] <= pov_nxt[k][l];
        end
      end
      out_r <= out_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

endmodule

[test/tb_quadratic_root_solver_core.sv]
module tb_quadratic_root_solver_core;
  import qrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 80;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  qrs_in_t             in_data;
  logic                out_valid;
  logic                out_stall;
  qrs_out_t            out_data;
  logic                cfg_wr_en;
  logic [TOL_BITS-1:0] cfg_wr_data;

  quadratic_root_solver_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  qrs_in_t  pending_eqs[$];
  qrs_out_t expected_roots[$];
  logic [TOL_BITS-1:0] tolerance;
  int errors;
  int in_gap;
  int out_gap;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit is_zero(logic signed [WORD_BITS-1:0] v);
    logic [WORD_BITS:0] m;
    m = v < 0 ? -{v[WORD_BITS-1], v} : {1'b0, v};
    return v == 0 || m < tolerance;
  endfunction

  // rounded num * 2^FRAC_BITS / den with saturation
  function automatic logic signed [WORD_BITS-1:0] divide_root(
      logic signed [127:0] num, logic signed [127:0] den, inout logic sat);
    logic [127:0] mn;
    logic [127:0] md;
    logic [127:0] q;
    logic [127:0] lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    q = ((mn << (FRAC_BITS + 1)) + md) / (md << 1);
    lim = (128'd1 << (WORD_BITS - 1)) - (neg ? 0 : 1);
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -q[WORD_BITS-1:0] : q[WORD_BITS-1:0];
  endfunction

  function automatic logic [127:0] int_sqrt(logic [127:0] v);
    logic [127:0] r;
    logic [127:0] b;
    r = 0;
    b = 128'd1 << 126;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - r - b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic qrs_out_t solve_equation(qrs_in_t e);
    qrs_out_t r;
    logic signed [127:0] a;
    logic signed [127:0] b;
    logic signed [127:0] c;
    logic signed [127:0] disc;
    logic signed [127:0] s;
    logic sat;
    a = e.coef_quadratic;
    b = e.coef_linear;
    c = e.coef_constant;
    sat = 1'b0;
    r = '0;
    if (is_zero(e.coef_quadratic)) begin
      if (is_zero(e.coef_linear)) begin
        r.root_count = is_zero(e.coef_constant) ? CNT_INF : CNT_NONE;
      end else begin
        r.first_root = divide_root(-c, b, sat);
        r.root_count = CNT_ONE;
      end
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        r.root_count = CNT_NONE;
      end else if (disc == 0) begin
        r.first_root = divide_root(-b, 2 * a, sat);
        r.second_root = r.first_root;
        r.root_count = CNT_ONE;
      end else begin
        s = int_sqrt(disc);
        r.first_root = divide_root(-b - s, 2 * a, sat);
        r.second_root = divide_root(-b + s, 2 * a, sat);
        r.root_count = CNT_TWO;
      end
    end
    r.range_overflow = sat;
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(0, 40) - 20;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      4: return (32'($urandom_range(0, 40)) - 20) << FRAC_BITS;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_roots.push_back(solve_equation(in_data));
        void'(pending_eqs.pop_front());
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_eqs.size() > 0) begin
        in_data <= pending_eqs[0];
        in_valid <= 1'b1;
        in_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: result with no expectation, actual %p", $realtime, out_data);
          errors++;
        end else begin
          if (out_data !== expected_roots[0]) begin
            $display("%0t: expected %p, actual %p", $realtime, expected_roots[0], out_data);
            errors++;
          end
          void'(expected_roots.pop_front());
        end
        out_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        out_stall <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_eq(logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b,
                         logic [WORD_BITS-1:0] c);
    qrs_in_t e;
    e.coef_quadratic = a;
    e.coef_linear = b;
    e.coef_constant = c;
    pending_eqs.push_back(e);
  endtask

  task automatic drain_and_set(logic [TOL_BITS-1:0] tol);
    while (pending_eqs.size() != 0 || in_valid || expected_roots.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= tol;
    tolerance = tol;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [TOL_BITS-1:0] tols[5];
    errors = 0;
    tolerance = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    push_eq(0, 0, 0);
    push_eq(0, 0, 1);
    push_eq(0, 32'h10000, 32'h20000);
    push_eq(0, 1, 32'h7fffffff);
    push_eq(0, 1, 32'h80000000);
    push_eq(32'h10000, 32'h20000, 32'h10000);
    push_eq(32'h10000, 0, 32'h10000);
    push_eq(32'h10000, 0, 32'hffff0000);
    push_eq(32'h10000, 0, 0);
    push_eq(1, 0, 32'hffffffff);
    push_eq(1, 32'h7fffffff, 0);
    push_eq(32'h80000000, 32'h80000000, 32'h7fffffff);
    push_eq(32'h7fffffff, 32'h7fffffff, 32'h80000000);
    push_eq(32'hffffffff, 32'h80000000, 32'h80000000);
    push_eq(32'h7fffffff, 1, 0);
    push_eq(32'h80000000, 0, 32'h7fffffff);
    push_eq(32'hffffffff, 32'hffffffff, 32'hffffffff);
    tols[0] = 0;
    tols[1] = 16'hffff;
    tols[2] = 16'd1;
    tols[3] = 16'd20;
    tols[4] = $urandom;
    for (int p = 0; p < 5; p++) begin
      drain_and_set(tols[p]);
      if (p == 1) begin
        push_eq(16'hffff, 16'hfffe, 0);
        push_eq(32'hffff0001, 32'h10000, 16'hffff);
      end
      for (int i = 0; i < 170; i++) push_eq(rand_coef(), rand_coef(), rand_coef());
    end
    while (pending_eqs.size() != 0 || in_valid || expected_roots.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver_core: match");
    end else begin
      $display("quadratic_root_solver_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("quadratic_root_solver_core: mismatch");
    $finish;
  end
endmodule
